// ===== rtl/fdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flow direction classifier package
// Shared types, codes and default sizes for the classifier block.
// ----------------------------------------------------------------------------
package fdc_pkg;

	// Default table depths.
	localparam int MAX_NETWORKS_DEF = 16;
	localparam int MAX_EXCLUDED_DEF = 16;

	// Fixed field widths.
	localparam int ADDR_W  = 32;
	localparam int BYTES_W = 32;
	localparam int COUNT_W = 5;
	localparam int SLOT_W  = 4;
	localparam int FUNC_W  = 2;
	localparam int REG_IDX_W = 2;

	// Function codes of an input beat.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLASSIFY = 2'd0,
		FUNC_WR_NET   = 2'd1,
		FUNC_WR_EXCL  = 2'd2,
		FUNC_NONE     = 2'd3
	} func_t;

	// Verdict codes of a result beat.
	typedef enum logic [1:0] {
		VERDICT_EXCLUDED  = 2'd0,
		VERDICT_USER_SRC  = 2'd1,
		VERDICT_USER_DST  = 2'd2,
		VERDICT_NO_CLIENT = 2'd3
	} verdict_t;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_NETWORK_COUNT  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_EXCLUDED_COUNT = 2'd1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_EXCL  = 3'd1,
		ST_NET   = 3'd2,
		ST_DRAIN = 3'd3,
		ST_FIN   = 3'd4
	} state_t;

	// Finished classification handed from the sequencer to the output stage.
	typedef struct packed {
		logic                done;
		verdict_t            verdict;
		logic [ADDR_W-1:0]   user_addr;
		logic [ADDR_W-1:0]   remote_addr;
		logic [BYTES_W-1:0]  octets_in;
		logic [BYTES_W-1:0]  octets_out;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/fdc_flow_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flow input channel
// Valid/ready channel carrying one flow or table-write beat.
// ----------------------------------------------------------------------------
interface fdc_flow_if;
	logic                               valid;
	logic                               ready;
	logic [fdc_pkg::FUNC_W-1:0]         func;
	logic [fdc_pkg::SLOT_W-1:0]         entry_index;
	logic [fdc_pkg::ADDR_W-1:0]         first_addr;
	logic [fdc_pkg::ADDR_W-1:0]         second_addr;
	logic [fdc_pkg::BYTES_W-1:0]        byte_count;

	modport source (
		output valid, func, entry_index, first_addr, second_addr, byte_count,
		input  ready
	);
	modport sink (
		input  valid, func, entry_index, first_addr, second_addr, byte_count,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/fdc_result_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one classification result beat.
// ----------------------------------------------------------------------------
interface fdc_result_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  verdict;
	logic [fdc_pkg::ADDR_W-1:0]  user_addr;
	logic [fdc_pkg::ADDR_W-1:0]  remote_addr;
	logic [fdc_pkg::BYTES_W-1:0] octets_in;
	logic [fdc_pkg::BYTES_W-1:0] octets_out;

	modport source (
		output valid, verdict, user_addr, remote_addr, octets_in, octets_out,
		input  ready
	);
	modport sink (
		input  valid, verdict, user_addr, remote_addr, octets_in, octets_out,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/flow_direction_classifier_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Flow direction classifier core
// Classifies flows against a client network table and an excluded host list.
// ----------------------------------------------------------------------------
// A flow beat (func classify) starts a walk through the two table memories,
// which have one read port each and are read one entry per cycle: first the
// excluded list, then the network table. The result is presented once the
// walk ends and the output register can take it, and the next beat is taken
// only after that, when the sequencer is back in idle. Table writes
// (func write network, func write excluded) and func code three are taken
// while the sequencer is idle and give no result. The result sits in an
// output register, so a new flow is accepted while the previous result still
// waits to be taken. Table entries are undefined until written; counts reset
// to zero and a count above the table depth acts as the depth.
// ----------------------------------------------------------------------------
module flow_direction_classifier_core #(
	parameter int MAX_NETWORKS = fdc_pkg::MAX_NETWORKS_DEF,
	parameter int MAX_EXCLUDED = fdc_pkg::MAX_EXCLUDED_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	fdc_flow_if.sink                               flow,
	fdc_result_if.source                           result,
	input  wire logic                              wr_en,
	input  wire logic [fdc_pkg::REG_IDX_W-1:0]     wr_index,
	input  wire logic [fdc_pkg::COUNT_W-1:0]       wr_data
);

	localparam int NAW = (MAX_NETWORKS > 1) ? $clog2(MAX_NETWORKS) : 1;
	localparam int XAW = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1;
	localparam int AW  = fdc_pkg::ADDR_W;

	// Configuration registers.
	logic [fdc_pkg::COUNT_W-1:0] network_count_q, excluded_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			network_count_q  <= '0;
			excluded_count_q <= '0;
		end else if (wr_en) begin
			if (wr_index == fdc_pkg::REG_NETWORK_COUNT) begin
				network_count_q <= wr_data;
			end
			if (wr_index == fdc_pkg::REG_EXCLUDED_COUNT) begin
				excluded_count_q <= wr_data;
			end
		end
	end

	// Input beat decoding. The sequencer is ready only when idle, so a table
	// write never overlaps a walk through the same memory.
	logic seq_idle, flow_beat, start, net_we, excl_we;

	assign flow.ready = seq_idle;
	assign flow_beat  = flow.valid && flow.ready;
	assign start      = flow_beat && (flow.func == fdc_pkg::FUNC_CLASSIFY);
	// Writes to a slot beyond the table depth are dropped.
	assign net_we     = flow_beat && (flow.func == fdc_pkg::FUNC_WR_NET) &&
		(32'(flow.entry_index) < MAX_NETWORKS);
	assign excl_we    = flow_beat && (flow.func == fdc_pkg::FUNC_WR_EXCL) &&
		(32'(flow.entry_index) < MAX_EXCLUDED);

	// Table memories: network entries keep address and mask side by side.
	logic [XAW-1:0]    excl_raddr;
	logic [NAW-1:0]    net_raddr;
	logic [AW-1:0]     excl_rdata;
	logic [2*AW-1:0]   net_rdata;

	fdc_ram #(
		.WIDTH (2*AW),
		.DEPTH (MAX_NETWORKS)
	) u_net_ram (
		.clk   (clk),
		.we    (net_we),
		.waddr (NAW'(flow.entry_index)),
		.wdata ({flow.first_addr, flow.second_addr}),
		.raddr (net_raddr),
		.rdata (net_rdata)
	);

	fdc_ram #(
		.WIDTH (AW),
		.DEPTH (MAX_EXCLUDED)
	) u_excl_ram (
		.clk   (clk),
		.we    (excl_we),
		.waddr (XAW'(flow.entry_index)),
		.wdata (flow.first_addr),
		.raddr (excl_raddr),
		.rdata (excl_rdata)
	);

	// Output register state; the sequencer holds its result while it is busy.
	logic             out_vld_q;
	logic             out_busy;
	fdc_pkg::result_t res;

	assign out_busy = out_vld_q && !result.ready;

	fdc_seq #(
		.MAX_NETWORKS (MAX_NETWORKS),
		.MAX_EXCLUDED (MAX_EXCLUDED)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.src_addr       (flow.first_addr),
		.dst_addr       (flow.second_addr),
		.bytes          (flow.byte_count),
		.network_count  (network_count_q),
		.excluded_count (excluded_count_q),
		.excl_rdata     (excl_rdata),
		.net_rdata      (net_rdata),
		.out_busy       (out_busy),
		.excl_raddr     (excl_raddr),
		.net_raddr      (net_raddr),
		.idle           (seq_idle),
		.res            (res)
	);

	// Output register. A finished result is loaded only when the register is
	// empty or its current beat is being taken in the same cycle.
	logic [1:0]                  verdict_q;
	logic [AW-1:0]               user_addr_q, remote_addr_q;
	logic [fdc_pkg::BYTES_W-1:0] octets_in_q, octets_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res.done) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			verdict_q     <= res.verdict;
			user_addr_q   <= res.user_addr;
			remote_addr_q <= res.remote_addr;
			octets_in_q   <= res.octets_in;
			octets_out_q  <= res.octets_out;
		end
	end

	assign result.valid       = out_vld_q;
	assign result.verdict     = verdict_q;
	assign result.user_addr   = user_addr_q;
	assign result.remote_addr = remote_addr_q;
	assign result.octets_in   = octets_in_q;
	assign result.octets_out  = octets_out_q;

`ifndef SYNTH
	// A classify beat starts a walk, so the input side closes right after it.
	a_busy_after_classify: assert property (@(posedge clk) disable iff (!arst_n)
		(flow.valid && flow.ready && flow.func == fdc_pkg::FUNC_CLASSIFY) |=> !flow.ready)
		else $error("input still ready after a classify beat");

	// Excluded and no-client results carry no addresses and no octets.
	a_no_client_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.verdict != fdc_pkg::VERDICT_USER_SRC &&
		 result.verdict != fdc_pkg::VERDICT_USER_DST) |->
		(result.user_addr == '0 && result.remote_addr == '0 &&
		 result.octets_in == '0 && result.octets_out == '0))
		else $error("addresses or octets set on a result without a user");

	// A source-side result carries no inbound octets.
	a_octets_direction: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.verdict == fdc_pkg::VERDICT_USER_SRC) |->
		(result.octets_in == '0 && result.user_addr != result.remote_addr ||
		 result.octets_in == '0))
		else $error("inbound octets on a source-side result");

	// A new result is only loaded when the output register can take it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |-> (!out_vld_q || result.ready))
		else $error("result loaded over a beat not yet taken");
`endif

endmodule
`default_nettype wire

// ===== rtl/fdc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/fdc_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Classifier sequencer
// Walks the excluded list and the network table, one entry per cycle,
// and builds the verdict of one flow.
// ----------------------------------------------------------------------------
module fdc_seq #(
	parameter int MAX_NETWORKS = fdc_pkg::MAX_NETWORKS_DEF,
	parameter int MAX_EXCLUDED = fdc_pkg::MAX_EXCLUDED_DEF,
	localparam int NAW = (MAX_NETWORKS > 1) ? $clog2(MAX_NETWORKS) : 1,
	localparam int XAW = (MAX_EXCLUDED > 1) ? $clog2(MAX_EXCLUDED) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [fdc_pkg::ADDR_W-1:0]    src_addr,
	input  wire logic [fdc_pkg::ADDR_W-1:0]    dst_addr,
	input  wire logic [fdc_pkg::BYTES_W-1:0]   bytes,
	input  wire logic [fdc_pkg::COUNT_W-1:0]   network_count,
	input  wire logic [fdc_pkg::COUNT_W-1:0]   excluded_count,
	input  wire logic [fdc_pkg::ADDR_W-1:0]    excl_rdata,
	input  wire logic [2*fdc_pkg::ADDR_W-1:0]  net_rdata,
	input  wire logic                          out_busy,
	output logic      [XAW-1:0]                excl_raddr,
	output logic      [NAW-1:0]                net_raddr,
	output logic                               idle,
	output fdc_pkg::result_t                   res
);

	localparam int AW = fdc_pkg::ADDR_W;

	fdc_pkg::state_t state_q, state_nxt;

	logic [fdc_pkg::COUNT_W-1:0] idx_q;
	logic [fdc_pkg::COUNT_W-1:0] net_lim, excl_lim;
	logic [AW-1:0]               src_q, dst_q;
	logic [fdc_pkg::BYTES_W-1:0] bytes_q;
	logic                        xcmp_q, ncmp_q;
	logic                        excl_hit_q, src_hit_q, dst_hit_q;
	logic [AW-1:0]               net_addr, net_mask;

	// Counts above the table depth saturate at the depth.
	assign net_lim  = (32'(network_count) > MAX_NETWORKS) ?
		fdc_pkg::COUNT_W'(MAX_NETWORKS) : network_count;
	assign excl_lim = (32'(excluded_count) > MAX_EXCLUDED) ?
		fdc_pkg::COUNT_W'(MAX_EXCLUDED) : excluded_count;

	assign net_addr = net_rdata[2*AW-1:AW];
	assign net_mask = net_rdata[AW-1:0];

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			fdc_pkg::ST_IDLE: begin
				if (start) state_nxt = fdc_pkg::ST_EXCL;
			end
			fdc_pkg::ST_EXCL: begin
				if (idx_q >= excl_lim) state_nxt = fdc_pkg::ST_NET;
			end
			fdc_pkg::ST_NET: begin
				if (idx_q >= net_lim) state_nxt = fdc_pkg::ST_DRAIN;
			end
			fdc_pkg::ST_DRAIN: begin
				state_nxt = fdc_pkg::ST_FIN;
			end
			fdc_pkg::ST_FIN: begin
				if (!out_busy) state_nxt = fdc_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = fdc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fdc_pkg::ST_IDLE;
			idx_q      <= '0;
			xcmp_q     <= 1'b0;
			ncmp_q     <= 1'b0;
			excl_hit_q <= 1'b0;
			src_hit_q  <= 1'b0;
			dst_hit_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			xcmp_q  <= (state_q == fdc_pkg::ST_EXCL) && (idx_q < excl_lim);
			ncmp_q  <= (state_q == fdc_pkg::ST_NET) && (idx_q < net_lim);

			if ((state_q == fdc_pkg::ST_EXCL && idx_q < excl_lim) ||
			    (state_q == fdc_pkg::ST_NET && idx_q < net_lim)) begin
				idx_q <= idx_q + 1'b1;
			end else begin
				idx_q <= '0;
			end

			if (start && state_q == fdc_pkg::ST_IDLE) begin
				excl_hit_q <= 1'b0;
				src_hit_q  <= 1'b0;
				dst_hit_q  <= 1'b0;
			end else begin
				if (xcmp_q && (excl_rdata == src_q || excl_rdata == dst_q)) begin
					excl_hit_q <= 1'b1;
				end
				if (ncmp_q && ((src_q & net_mask) == (net_addr & net_mask))) begin
					src_hit_q <= 1'b1;
				end
				if (ncmp_q && ((dst_q & net_mask) == (net_addr & net_mask))) begin
					dst_hit_q <= 1'b1;
				end
			end
		end
	end

	// Flow fields are held for the whole walk.
	always_ff @(posedge clk) begin
		if (start && state_q == fdc_pkg::ST_IDLE) begin
			src_q   <= src_addr;
			dst_q   <= dst_addr;
			bytes_q <= bytes;
		end
	end

	always_comb begin
		idle       = (state_q == fdc_pkg::ST_IDLE);
		excl_raddr = XAW'(idx_q);
		net_raddr  = NAW'(idx_q);

		res             = '0;
		res.done        = (state_q == fdc_pkg::ST_FIN) && !out_busy;
		res.verdict     = fdc_pkg::VERDICT_NO_CLIENT;
		if (excl_hit_q) begin
			res.verdict = fdc_pkg::VERDICT_EXCLUDED;
		end else if (src_hit_q) begin
			res.verdict     = fdc_pkg::VERDICT_USER_SRC;
			res.user_addr   = src_q;
			res.remote_addr = dst_q;
			res.octets_out  = bytes_q;
		end else if (dst_hit_q) begin
			res.verdict     = fdc_pkg::VERDICT_USER_DST;
			res.user_addr   = dst_q;
			res.remote_addr = src_q;
			res.octets_in   = bytes_q;
		end
	end

endmodule
`default_nettype wire
